// ----- hw/rtl/fcs_pkg.sv -----
// Shared types and constants for the framed command sender.
// No dependencies; every other file of the block imports this package.
package fcs_pkg;

  // Default depth of the packet store (length byte plus payload).
  localparam int FCS_BUF_DEPTH_DEF = 32;

  // Widths of the channel payloads.
  localparam int REQ_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int RETRY_W   = 4;
  localparam int CFG_IDX_W = 3;

  // Request codes carried by an input item.
  localparam logic [REQ_W-1:0] REQ_PKT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RX   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0]  START_CODE_RST   = 8'd2;
  localparam logic [BYTE_W-1:0]  ACK_CODE_RST     = 8'd6;
  localparam logic [BYTE_W-1:0]  INVALID_CODE_RST = 8'd21;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST  = 4'd3;
  localparam logic [BYTE_W-1:0]  TIMEOUT_RST      = 8'd70;

  // Result kinds.
  localparam logic OUT_KIND_TX     = 1'b0;
  localparam logic OUT_KIND_STATUS = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_START,
    ST_BODY,
    ST_CHK,
    ST_PASS,
    ST_FAIL
  } fcs_state_t;

  // Which result the datapath puts in the output register.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_START,
    EM_BODY,
    EM_CHK,
    EM_PASS,
    EM_FAIL
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  len_wr;       // store the length byte, loaded count to one
    logic  byte_wr;      // store a payload byte, advance loaded count
    logic  attempt_clr;  // new request: attempt count restarts
    logic  tick_inc;     // count one tick (saturating)
    logic  frame_begin;  // rewind the read pointer, count an attempt
    logic  req_clr;      // request finished: clear counters
    emit_t emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_bad;       // length byte is zero or does not fit
    logic load_done;     // this payload byte completes the packet
    logic is_ack;
    logic is_inv;
    logic tick_expired;  // this tick reaches the timeout
    logic retry_spent;   // no attempts left
    logic body_last;     // read pointer is on the last stored byte
    logic can_emit;      // output register can take a result this cycle
  } dp_sts_t;

endpackage

// ----- hw/rtl/fcs_in_if.sv -----
// Input channel of the framed command sender: valid/ready plus request payload.
// Depends on fcs_pkg for field widths.
interface fcs_in_if
  import fcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

// ----- hw/rtl/fcs_out_if.sv -----
// Result channel of the framed command sender: valid/ready plus result payload.
// Depends on fcs_pkg for field widths.
interface fcs_out_if
  import fcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] tx_byte;
  logic              sent_ok;
  logic              last;

  modport source (output valid, output out_kind, output tx_byte, output sent_ok,
                  output last, input ready);
  modport sink (input valid, input out_kind, input tx_byte, input sent_ok,
                input last, output ready);
endinterface

// ----- hw/rtl/fcs_cfg_if.sv -----
// Configuration write channel: valid/ready plus register index and data.
// Depends on fcs_pkg for field widths.
interface fcs_cfg_if
  import fcs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fcs_ctrl.sv -----
// Controller state machine of the framed command sender.
// Depends on fcs_pkg; drives dp_cmd_t to the datapath and reads dp_sts_t.
module fcs_ctrl
  import fcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_ready,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  fcs_state_t state_r, state_nxt;
  logic       in_fire;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Items are taken only in the idle, loading and waiting phases.
  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_LOAD) || (state_r == ST_WAIT);
  assign in_fire  = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    cmd.len_wr      = 1'b0;
    cmd.byte_wr     = 1'b0;
    cmd.attempt_clr = 1'b0;
    cmd.tick_inc    = 1'b0;
    cmd.frame_begin = 1'b0;
    cmd.req_clr     = 1'b0;
    cmd.emit        = EM_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_req_type == REQ_PKT) begin
          if (sts.len_bad) begin
            cmd.req_clr = 1'b1;
            state_nxt   = ST_FAIL;
          end else begin
            cmd.len_wr = 1'b1;
            state_nxt  = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (in_fire && in_req_type == REQ_PKT) begin
          cmd.byte_wr = 1'b1;
          if (sts.load_done) begin
            cmd.attempt_clr = 1'b1;
            cmd.frame_begin = 1'b1;
            state_nxt       = ST_START;
          end
        end
      end
      ST_WAIT: begin
        if (in_fire && in_req_type == REQ_RX) begin
          if (sts.is_ack) begin
            cmd.req_clr = 1'b1;
            state_nxt   = ST_PASS;
          end else if (sts.is_inv) begin
            cmd.req_clr = 1'b1;
            state_nxt   = ST_FAIL;
          end else if (sts.retry_spent) begin
            cmd.req_clr = 1'b1;
            state_nxt   = ST_FAIL;
          end else begin
            cmd.frame_begin = 1'b1;
            state_nxt       = ST_START;
          end
        end else if (in_fire && in_req_type == REQ_TICK) begin
          cmd.tick_inc = 1'b1;
          if (sts.tick_expired) begin
            if (sts.retry_spent) begin
              cmd.req_clr = 1'b1;
              state_nxt   = ST_FAIL;
            end else begin
              cmd.frame_begin = 1'b1;
              state_nxt       = ST_START;
            end
          end
        end
      end
      ST_START: begin
        if (sts.can_emit) begin
          cmd.emit  = EM_START;
          state_nxt = ST_BODY;
        end
      end
      ST_BODY: begin
        if (sts.can_emit) begin
          cmd.emit = EM_BODY;
          if (sts.body_last) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (sts.can_emit) begin
          cmd.emit  = EM_CHK;
          state_nxt = ST_WAIT;
        end
      end
      ST_PASS: begin
        if (sts.can_emit) begin
          cmd.emit  = EM_PASS;
          state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (sts.can_emit) begin
          cmd.emit  = EM_FAIL;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fcs_dp.sv -----
// Datapath of the framed command sender: configuration registers, packet
// store, counters, check byte and output register. Depends on fcs_pkg.
module fcs_dp
  import fcs_pkg::*;
#(
  parameter int BUF_DEPTH = FCS_BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fcs_cfg_if.sink           cfg_if,
  input  logic [BYTE_W-1:0] in_data_byte,
  fcs_out_if.source         out_if,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);

  localparam int IDXW = $clog2(BUF_DEPTH);
  localparam int LCW  = $clog2(BUF_DEPTH + 1);

  // Configuration registers.
  logic [BYTE_W-1:0]  start_code_r;
  logic [BYTE_W-1:0]  ack_code_r;
  logic [BYTE_W-1:0]  invalid_code_r;
  logic [RETRY_W-1:0] retry_limit_r;
  logic [BYTE_W-1:0]  timeout_r;

  // Packet store and its registered read port.
  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic [IDXW-1:0]    len_r;
  logic [LCW-1:0]     loaded_r, loaded_nxt;
  logic [IDXW-1:0]    idx_r, idx_nxt;
  logic [RETRY_W-1:0] attempt_r, attempt_nxt;
  logic [BYTE_W-1:0]  tick_r, tick_nxt, tick_inc_val;
  logic [BYTE_W-1:0]  chk_r, chk_nxt;
  logic [RETRY_W-1:0] limit_eff;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r;
  logic [BYTE_W-1:0] tx_byte_r;
  logic              sent_ok_r;
  logic              last_r;

  // Configuration writes; unknown indexes are dropped.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r   <= START_CODE_RST;
      ack_code_r     <= ACK_CODE_RST;
      invalid_code_r <= INVALID_CODE_RST;
      retry_limit_r  <= RETRY_LIMIT_RST;
      timeout_r      <= TIMEOUT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_START_CODE:   start_code_r   <= cfg_if.data;
        CFG_ACK_CODE:     ack_code_r     <= cfg_if.data;
        CFG_INVALID_CODE: invalid_code_r <= cfg_if.data;
        CFG_RETRY_LIMIT:  retry_limit_r  <= cfg_if.data[RETRY_W-1:0];
        CFG_TIMEOUT:      timeout_r      <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Store writes; the read address follows the next read pointer so that
  // rd_q always holds the entry under idx_r.
  always_ff @(posedge clk) begin
    if (cmd.len_wr) begin
      mem[IDXW'(0)] <= in_data_byte;
    end else if (cmd.byte_wr) begin
      mem[loaded_r[IDXW-1:0]] <= in_data_byte;
    end
    rd_q <= mem[idx_nxt];
  end

  // Status toward the controller.
  assign tick_inc_val = (tick_r == {BYTE_W{1'b1}}) ? tick_r : tick_r + BYTE_W'(1);
  assign limit_eff    = (retry_limit_r == '0) ? RETRY_W'(1) : retry_limit_r;

  always_comb begin
    sts.len_bad      = (in_data_byte == '0) || (int'(in_data_byte) > BUF_DEPTH - 1);
    sts.load_done    = loaded_r >= LCW'(len_r);
    sts.is_ack       = in_data_byte == ack_code_r;
    sts.is_inv       = in_data_byte == invalid_code_r;
    sts.tick_expired = tick_inc_val >= timeout_r;
    sts.retry_spent  = attempt_r >= limit_eff;
    sts.body_last    = idx_r == len_r;
    sts.can_emit     = !out_valid_r || out_if.ready;
  end

  // Counter updates.
  always_comb begin
    loaded_nxt  = loaded_r;
    attempt_nxt = attempt_r;
    tick_nxt    = tick_r;
    idx_nxt     = idx_r;
    chk_nxt     = chk_r;
    if (cmd.len_wr) begin
      loaded_nxt = LCW'(1);
    end else if (cmd.byte_wr) begin
      loaded_nxt = loaded_r + LCW'(1);
    end
    if (cmd.tick_inc) begin
      tick_nxt = tick_inc_val;
    end
    if (cmd.frame_begin) begin
      attempt_nxt = (cmd.attempt_clr ? '0 : attempt_r) + RETRY_W'(1);
      tick_nxt    = '0;
      idx_nxt     = '0;
    end
    if (cmd.req_clr) begin
      loaded_nxt  = '0;
      attempt_nxt = '0;
      tick_nxt    = '0;
    end
    if (cmd.emit == EM_START) begin
      chk_nxt = start_code_r;
    end else if (cmd.emit == EM_BODY) begin
      chk_nxt = chk_r ^ rd_q;
      idx_nxt = idx_r + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      attempt_r <= '0;
      tick_r    <= '0;
      idx_r     <= '0;
    end else begin
      loaded_r  <= loaded_nxt;
      attempt_r <= attempt_nxt;
      tick_r    <= tick_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // Length copy and check byte accumulator.
  always_ff @(posedge clk) begin
    if (cmd.len_wr) begin
      len_r <= in_data_byte[IDXW-1:0];
    end
    chk_r <= chk_nxt;
  end

  // Output register.
  assign out_valid_nxt = (cmd.emit != EM_NONE) ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EM_START: begin
        out_kind_r <= OUT_KIND_TX;
        tx_byte_r  <= start_code_r;
        sent_ok_r  <= 1'b0;
        last_r     <= 1'b0;
      end
      EM_BODY: begin
        out_kind_r <= OUT_KIND_TX;
        tx_byte_r  <= rd_q;
        sent_ok_r  <= 1'b0;
        last_r     <= 1'b0;
      end
      EM_CHK: begin
        out_kind_r <= OUT_KIND_TX;
        tx_byte_r  <= chk_r;
        sent_ok_r  <= 1'b0;
        last_r     <= 1'b1;
      end
      EM_PASS: begin
        out_kind_r <= OUT_KIND_STATUS;
        tx_byte_r  <= '0;
        sent_ok_r  <= 1'b1;
        last_r     <= 1'b1;
      end
      EM_FAIL: begin
        out_kind_r <= OUT_KIND_STATUS;
        tx_byte_r  <= '0;
        sent_ok_r  <= 1'b0;
        last_r     <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_kind = out_kind_r;
  assign out_if.tx_byte  = tx_byte_r;
  assign out_if.sent_ok  = sent_ok_r;
  assign out_if.last     = last_r;

endmodule

// ----- hw/rtl/framed_command_sender_with_retry.sv -----
// Framed command sender with reply wait and retry: top level.
// An input item is accepted in any cycle spent idle, loading or waiting for a reply.
// The item that completes a packet of L bytes or starts a resend closes the input
// while the L+3 frame items enter the output register, one per cycle with out ready
// high; the controller state register and then the output register lie between the
// accept and the first valid frame item, and likewise between a status item's cause
// and its valid. Reset is synchronous and active low; the store is not cleared.
module framed_command_sender_with_retry
  import fcs_pkg::*;
#(
  parameter int BUF_DEPTH = FCS_BUF_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fcs_in_if.sink    in_if,
  fcs_out_if.source out_if,
  fcs_cfg_if.sink   cfg_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_if.ready = in_ready;

  // Sequencing of load, send, wait and status.
  fcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Storage, counters and result register.
  fcs_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_if       (cfg_if),
    .in_data_byte (in_if.data_byte),
    .out_if       (out_if),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
